[hw/rtl/bpe_pkg.sv]
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared constants for the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpe_pkg;

   localparam int DEGREE_DEFAULT      = 3;
   localparam int T_FRAC_BITS_DEFAULT = 16;
   localparam int COORD_BITS_DEFAULT  = 16;

   localparam int NUM_POINT_REGS = 8;
   localparam int CSR_ADDR_BITS  = $clog2(NUM_POINT_REGS);

   // register map: point p, axis a (0 = x, 1 = y) at REG_POINT0_X + 2*p + a
   localparam int REG_POINT0_X = 0;
   localparam int REG_POINT0_Y = 1;
   localparam int REG_POINT1_X = 2;
   localparam int REG_POINT1_Y = 3;
   localparam int REG_POINT2_X = 4;
   localparam int REG_POINT2_Y = 5;
   localparam int REG_POINT3_X = 6;
   localparam int REG_POINT3_Y = 7;

   localparam int POINT_RESET [NUM_POINT_REGS] = '{50, 50, 200, 50, 200, 200, 50, 200};

endpackage

`default_nettype wire

[hw/rtl/bpe_lerp_cell.sv]
// ----------------------------------------------------------------------------
// bpe_lerp_cell
// One interpolation cell: q = a*ONE + t*(b - a), exact, two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module bpe_lerp_cell #(
   parameter int WIDTH_IN = 16,
   parameter int T_BITS   = 16
) (
   input  logic                              clock,
   input  logic                              en_diff,
   input  logic                              en_mul,
   input  logic signed [WIDTH_IN-1:0]        a,
   input  logic signed [WIDTH_IN-1:0]        b,
   input  logic        [T_BITS:0]            t,
   output logic signed [WIDTH_IN+T_BITS-1:0] q
);

   localparam int PROD_BITS = WIDTH_IN + T_BITS + 3;

   logic signed [WIDTH_IN:0]          diff_in;
   logic signed [WIDTH_IN:0]          diff_ff;
   logic signed [WIDTH_IN-1:0]        a_ff;
   logic signed [T_BITS+1:0]          t_s;
   logic signed [PROD_BITS-1:0]       prod;
   logic signed [PROD_BITS-1:0]       base;
   logic signed [PROD_BITS-1:0]       sum;
   logic signed [WIDTH_IN+T_BITS-1:0] q_in;
   logic signed [WIDTH_IN+T_BITS-1:0] q_ff;

   assign diff_in = (WIDTH_IN+1)'(b) - (WIDTH_IN+1)'(a);

   always_ff @(posedge clock) begin
      if (en_diff) begin
         diff_ff <= diff_in;
         a_ff    <= a;
      end
   end

   assign t_s  = $signed({1'b0, t});
   assign prod = PROD_BITS'(diff_ff) * PROD_BITS'(t_s);
   assign base = PROD_BITS'(a_ff) <<< T_BITS;
   assign sum  = base + prod;
   // t stays within [0, ONE], so the result is a convex mix and fits
   assign q_in = sum[WIDTH_IN+T_BITS-1:0];

   always_ff @(posedge clock) begin
      if (en_mul) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

`default_nettype wire

[hw/rtl/bpe_round_cell.sv]
// ----------------------------------------------------------------------------
// bpe_round_cell
// Round half up, drop the fraction, saturate, and hold the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bpe_round_cell #(
   parameter int WIDTH    = 64,
   parameter int SHIFT    = 48,
   parameter int OUT_BITS = 16
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [WIDTH-1:0]    v,
   output logic        [OUT_BITS-1:0] q
);

   localparam logic [WIDTH:0]      HALF  = (WIDTH+1)'(1) << (SHIFT-1);
   localparam logic [OUT_BITS-1:0] MAX_V = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic [OUT_BITS-1:0] MIN_V = {1'b1, {(OUT_BITS-1){1'b0}}};

   logic signed [WIDTH:0]    sum;
   logic        [OUT_BITS:0] whole;
   logic        [OUT_BITS-1:0] q_in;
   logic        [OUT_BITS-1:0] q_ff;

   assign sum   = (WIDTH+1)'(v) + $signed(HALF);
   assign whole = sum[WIDTH:SHIFT];

   always_comb begin
      if (whole[OUT_BITS] != whole[OUT_BITS-1]) begin
         q_in = whole[OUT_BITS] ? MIN_V : MAX_V;
      end else begin
         q_in = whole[OUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

`default_nettype wire

[hw/rtl/bezier_point_evaluator.sv]
// ----------------------------------------------------------------------------
// bezier_point_evaluator
// Cubic Bezier point evaluation as a triangle of exact interpolation cells.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  req     | in  | tvalid / tready   | tdata: param_t
//  rsp     | out | tvalid / tready   | tdata: curve_x, curve_y
//  csr     | in  | we (no wait)      | addr, wdata: point registers
//
//  One request per cycle while the response is not stalled, through 2*DEGREE+2
//  register stages (input register, two per interpolation level,
//  rounding/output register).
//  Each stage moves when it is empty or its successor moves, so bubbles close
//  up while the output is stalled.
//  Synchronous reset clears the valid chain and loads the default points.
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_point_evaluator #(
   parameter  int DEGREE          = bpe_pkg::DEGREE_DEFAULT,
   parameter  int T_FRACTION_BITS = bpe_pkg::T_FRAC_BITS_DEFAULT,
   parameter  int COORD_BITS      = bpe_pkg::COORD_BITS_DEFAULT,
   localparam int REQ_BITS        = ((T_FRACTION_BITS + 1 + 7) / 8) * 8,
   localparam int RSP_BITS        = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [REQ_BITS-1:0]                req_tdata,   // param_t
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [RSP_BITS-1:0]                rsp_tdata,   // curve_x, curve_y
   input  logic                               csr_we,
   input  logic [bpe_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [COORD_BITS-1:0]              csr_wdata
);

   import bpe_pkg::*;

   localparam int TB     = T_FRACTION_BITS;
   localparam int NS     = 2 * DEGREE + 2;
   localparam int WMAX   = COORD_BITS + DEGREE * TB;
   localparam logic [TB:0] ONE = {1'b1, {TB{1'b0}}};

   logic signed [COORD_BITS-1:0] point_ff [NUM_POINT_REGS];

   logic [NS-1:0] en;
   logic [NS-1:0] v_in;
   logic [NS-1:0] v_ff;
   logic [TB:0]   t_in;
   logic [TB:0]   t_ff [2*DEGREE];

   logic signed [WMAX-1:0] lvl [2][DEGREE+1][DEGREE+1];
   logic [COORD_BITS-1:0]  coord [2];

   // point registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_POINT_REGS; i++) begin
            point_ff[i] <= COORD_BITS'(POINT_RESET[i]);
         end
      end else if (csr_we) begin
         point_ff[csr_addr] <= csr_wdata;
      end
   end

   // stage enables, last stage first
   always_comb begin
      en[NS-1] = !v_ff[NS-1] || rsp_tready;
      for (int s = NS-2; s >= 0; s--) begin
         en[s] = !v_ff[s] || en[s+1];
      end
   end

   always_comb begin
      v_in[0] = req_tvalid;
      for (int s = 1; s < NS; s++) begin
         v_in[s] = v_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (en[s]) begin
               v_ff[s] <= v_in[s];
            end
         end
      end
   end

   // clamp t above one
   assign t_in = req_tdata[TB] ? ONE : req_tdata[TB:0];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         t_ff[0] <= t_in;
      end
      for (int s = 1; s < 2*DEGREE; s++) begin
         if (en[s]) begin
            t_ff[s] <= t_ff[s-1];
         end
      end
   end

   assign req_tready = en[0];

   genvar ax, k, j;
   generate
      for (ax = 0; ax < 2; ax++) begin : g_axis
         for (j = 0; j <= DEGREE; j++) begin : g_pt
            assign lvl[ax][0][j] = WMAX'(point_ff[REG_POINT0_X + 2*j + ax]);
         end
         for (k = 1; k <= DEGREE; k++) begin : g_level
            localparam int WI = COORD_BITS + (k-1) * TB;
            for (j = 0; j <= DEGREE; j++) begin : g_cell
               if (j <= DEGREE - k) begin : g_used
                  logic signed [WI+TB-1:0] q;
                  bpe_lerp_cell #(
                     .WIDTH_IN (WI),
                     .T_BITS   (TB)
                  ) u_cell (
                     .clock   (clock),
                     .en_diff (en[2*k-1]),
                     .en_mul  (en[2*k]),
                     .a       (lvl[ax][k-1][j][WI-1:0]),
                     .b       (lvl[ax][k-1][j+1][WI-1:0]),
                     .t       (t_ff[2*k-1]),
                     .q       (q)
                  );
                  assign lvl[ax][k][j] = WMAX'(q);
               end else begin : g_unused
                  assign lvl[ax][k][j] = '0;
               end
            end
         end
         bpe_round_cell #(
            .WIDTH    (WMAX),
            .SHIFT    (DEGREE * TB),
            .OUT_BITS (COORD_BITS)
         ) u_round (
            .clock (clock),
            .en    (en[NS-1]),
            .v     (lvl[ax][DEGREE][0]),
            .q     (coord[ax])
         );
      end
   endgenerate

   assign rsp_tvalid = v_ff[NS-1];
   assign rsp_tdata  = RSP_BITS'({coord[1], coord[0]});

endmodule

`default_nettype wire

[hw/rtl/bpe_checker.sv]
// ----------------------------------------------------------------------------
// bpe_checker
// Port-level checks for the Bezier point evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpe_checker #(
   parameter int RSP_BITS = 32
) (
   input logic                clock,
   input logic                reset,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata
);

   // reset empties the pipeline
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // requests are refused only behind a stalled response
   a_ready_backpressure : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request refused without output stall");

   // a refused request with the output draining leaves ready set or a response valid next cycle
   a_ready_recovers : assert property (@(posedge clock) disable iff (reset)
      !req_tready && rsp_tready |=> req_tready || rsp_tvalid)
      else $error("ready not restored after drain");

endmodule

bind bezier_point_evaluator bpe_checker #(
   .RSP_BITS ($bits(rsp_tdata))
) u_bpe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cubic Bezier point evaluator.
// A short table of curve parameters runs against the reset control points,
// with the end points, clamping above 1.0 and the midpoint typed in. Random
// requests then follow under several point settings, saturating and crossing
// extremes among them. Responses not typed in are compared with an exact
// wide-integer Bernstein evaluation. Sender and receiver stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import bpe_pkg::*;

   localparam int TF        = T_FRAC_BITS_DEFAULT;
   localparam int CB        = COORD_BITS_DEFAULT;
   localparam int REQ_W     = ((TF + 1 + 7) / 8) * 8;
   localparam int RSP_W     = ((2 * CB + 7) / 8) * 8;
   localparam int LATENCY   = 2 * DEGREE_DEFAULT + 2;
   localparam int SETTINGS  = 9;
   localparam int PER_SET   = 210;
   localparam int RAND_REQS = SETTINGS * PER_SET;
   localparam int DIR_ROWS  = 15;

   localparam logic [TF:0]       T_ONE     = (TF + 1)'(1) << TF;
   localparam longint            COORD_MAX = (64'sd1 <<< (CB - 1)) - 1;
   localparam longint            COORD_MIN = -(64'sd1 <<< (CB - 1));

   typedef logic signed [CB-1:0] coord_type;

   typedef struct {
      coord_type x;
      coord_type y;
   } curve_point_type;

   typedef struct packed {
      logic [TF:0] t;
      logic        known;
      coord_type   x;
      coord_type   y;
   } param_row_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;    // param_t
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;    // curve_x, curve_y
   logic             csr_we;
   logic [CSR_ADDR_BITS-1:0] csr_addr;
   logic [CB-1:0]    csr_wdata;

   coord_type       point_regs [NUM_POINT_REGS];
   curve_point_type pending_points [$];
   int              sender_idle_pct;
   int              receiver_idle_pct;
   int              mismatch_count;
   int              request_count;
   int              response_count;

   // reset points: t = 0 gives P0, t >= 1.0 gives P3, t = 0.5 is (1300/8, 1000/8)
   param_row_type param_rows [DIR_ROWS] = '{
      '{17'd0,      1'b1, 16'sd50,  16'sd50},
      '{17'd65536,  1'b1, 16'sd50,  16'sd200},
      '{17'd65537,  1'b1, 16'sd50,  16'sd200},
      '{17'd98304,  1'b1, 16'sd50,  16'sd200},
      '{17'd131071, 1'b1, 16'sd50,  16'sd200},
      '{17'd32768,  1'b1, 16'sd163, 16'sd125},
      '{17'd1,      1'b0, 16'sd0,   16'sd0},
      '{17'd2,      1'b0, 16'sd0,   16'sd0},
      '{17'd16384,  1'b0, 16'sd0,   16'sd0},
      '{17'd32767,  1'b0, 16'sd0,   16'sd0},
      '{17'd32769,  1'b0, 16'sd0,   16'sd0},
      '{17'd49152,  1'b0, 16'sd0,   16'sd0},
      '{17'd65535,  1'b0, 16'sd0,   16'sd0},
      '{17'h0AAAA,  1'b0, 16'sd0,   16'sd0},
      '{17'h05555,  1'b0, 16'sd0,   16'sd0}
   };

   bezier_point_evaluator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("timeout: %0d responses still pending", pending_points.size());
      $display("FAILURE");
      $finish;
   end

   function automatic curve_point_type bezier_point(input logic [TF:0] t_raw);
      logic signed [127:0] tw;
      logic signed [127:0] uw;
      logic signed [127:0] acc;
      logic signed [127:0] coord;
      logic signed [127:0] weight [4];
      coord_type           axis_val [2];
      curve_point_type     pt;
      tw = 128'((t_raw > T_ONE) ? T_ONE : t_raw);
      uw = (128'sd1 <<< TF) - tw;
      weight[0] = uw * uw * uw;
      weight[1] = 3 * tw * uw * uw;
      weight[2] = 3 * tw * tw * uw;
      weight[3] = tw * tw * tw;
      for (int a = 0; a < 2; a++) begin
         acc = 128'sd1 <<< (3 * TF - 1);
         for (int i = 0; i < 4; i++) begin
            coord = 128'(point_regs[2 * i + a]);
            acc += weight[i] * coord;
         end
         acc = acc >>> (3 * TF);
         if (acc > COORD_MAX) begin
            axis_val[a] = coord_type'(COORD_MAX);
         end else if (acc < COORD_MIN) begin
            axis_val[a] = coord_type'(COORD_MIN);
         end else begin
            axis_val[a] = coord_type'(acc);
         end
      end
      pt.x = axis_val[0];
      pt.y = axis_val[1];
      return pt;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endtask

   task automatic send_point(input logic [TF:0] t, input logic known,
                             input coord_type ex, input coord_type ey);
      curve_point_type want;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(t);
      do @(posedge clock); while (!req_tready);
      if (known) begin
         want.x = ex;
         want.y = ey;
      end else begin
         want = bezier_point(t);
      end
      pending_points.push_back(want);
      request_count++;
   endtask

   task automatic write_points();
      for (int i = 0; i < NUM_POINT_REGS; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= CSR_ADDR_BITS'(REG_POINT0_X + i);
         csr_wdata <= point_regs[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic choose_points(input int setting);
      for (int i = 0; i < NUM_POINT_REGS; i++) begin
         case (setting)
            1: begin
               point_regs[i] = coord_type'(COORD_MAX);
            end
            2: begin
               point_regs[i] = coord_type'(COORD_MIN);
            end
            3: begin
               // x and y swing between opposite rails
               point_regs[i] = ((i ^ (i >> 1)) & 1) ? coord_type'(COORD_MAX)
                                                    : coord_type'(COORD_MIN);
            end
            6: begin
               point_regs[i] = coord_type'($urandom_range(200)) - coord_type'(100);
            end
            default: begin
               point_regs[i] = coord_type'($urandom);
            end
         endcase
      end
   endtask

   function automatic logic [TF:0] random_param();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         return ($urandom_range(TF + 1) == 0) ? T_ONE
                                              : (TF + 1)'($urandom & 32'(T_ONE - 1'b1));
      end else if (pick < 80) begin
         case ($urandom_range(3))
            0: return '0;
            1: return (TF + 1)'(1);
            2: return T_ONE - 1'b1;
            default: return T_ONE;
         endcase
      end
      return (TF + 1)'($urandom);
   endfunction

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin : check_response
      curve_point_type want;
      coord_type       got_x;
      coord_type       got_y;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_x = rsp_tdata[CB-1:0];
         got_y = rsp_tdata[2*CB-1:CB];
         response_count++;
         if (pending_points.size() == 0) begin
            note_mismatch($sformatf("unexpected response x=%0d y=%0d", got_x, got_y));
         end else begin
            want = pending_points.pop_front();
            if (got_x !== want.x) begin
               note_mismatch($sformatf("curve_x expected %0d got %0d", want.x, got_x));
            end
            if (got_y !== want.y) begin
               note_mismatch($sformatf("curve_y expected %0d got %0d", want.y, got_y));
            end
         end
      end
   end

   initial begin
      int rand_sent;
      mismatch_count    = 0;
      request_count     = 0;
      response_count    = 0;
      rand_sent         = 0;
      sender_idle_pct   = 32;
      receiver_idle_pct = 55;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      csr_we     <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      for (int i = 0; i < NUM_POINT_REGS; i++) begin
         point_regs[i] = coord_type'(POINT_RESET[i]);
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int s = 0; s < SETTINGS; s++) begin
         if (s == 0) begin
            foreach (param_rows[r]) begin
               send_point(param_rows[r].t, param_rows[r].known,
                          param_rows[r].x, param_rows[r].y);
            end
         end else begin
            req_tvalid <= 1'b0;
            while (pending_points.size() != 0) @(posedge clock);
            repeat (LATENCY) @(posedge clock);
            choose_points(s);
            write_points();
         end
         for (int n = 0; n < PER_SET; n++) begin
            if (rand_sent < RAND_REQS / 3) begin
               sender_idle_pct   = 32;
               receiver_idle_pct = 55;
            end else if (rand_sent < 2 * RAND_REQS / 3) begin
               sender_idle_pct   = 55;
               receiver_idle_pct = 32;
            end else begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
            send_point(random_param(), 1'b0, '0, '0);
            rand_sent++;
         end
      end

      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);

      $display("%0d requests, %0d responses over %0d point settings", request_count,
               response_count, SETTINGS);
      $display("reset, rail and crossing points; t from 0 through clamped values above 1.0");
      if (mismatch_count == 0 && pending_points.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
